/* hdl/matrix_multiply_unit_defines.svh */
// ----------------------------------------------------------------------------
// matrix_multiply_unit_defines.svh
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef MATRIX_MULTIPLY_UNIT_DEFINES_SVH
`define MATRIX_MULTIPLY_UNIT_DEFINES_SVH

// same-cycle implication, checked while reset is released
`define MMU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("matrix multiply unit: assertion failed");

// next-cycle implication, checked while reset is released
`define MMU_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("matrix multiply unit: assertion failed");

// next-cycle implication that also holds across reset
`define MMU_ASSERT_NXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("matrix multiply unit: assertion failed");

`endif

/* hdl/mmu_pkg.sv */
// ----------------------------------------------------------------------------
// mmu_pkg
// types, constants and helpers of the matrix multiply unit
// ----------------------------------------------------------------------------
package mmu_pkg;

    localparam int MAX_DIM = 8;
    localparam int DIM_W   = $clog2(MAX_DIM);
    localparam int ADDR_W  = 2 * DIM_W;
    localparam int DEPTH   = MAX_DIM * MAX_DIM;
    localparam int ELEM_W  = 16;
    localparam int PROD_W  = 2 * ELEM_W;
    localparam int ACC_W   = 36;
    localparam int CFG_W   = 4;
    localparam int CFG_IDX_W = 2;
    localparam int REQ_W   = 2;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 48;

    typedef enum logic [REQ_W-1:0] {
        REQ_WR_A    = 2'd0,
        REQ_WR_B    = 2'd1,
        REQ_COMPUTE = 2'd2
    } t_req;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROWS_OF_A  = 2'd0,
        CFG_INNER_SIZE = 2'd1,
        CFG_COLS_OF_B  = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT
    } t_state;

    // tag that travels with one multiply through the read and multiply stages
    typedef struct packed {
        logic             valid;
        logic             first;
        logic             last;
        logic             last_run;
        logic [DIM_W-1:0] row;
        logic [DIM_W-1:0] col;
    } t_mac_ctl;

    // size register to last index, zero taken as one, large values clamped
    function automatic logic [DIM_W-1:0] last_index(input logic [CFG_W-1:0] dim);
        logic [DIM_W-1:0] res;
        if (dim == '0) begin
            res = '0;
        end else if (dim > CFG_W'(MAX_DIM)) begin
            res = DIM_W'(MAX_DIM - 1);
        end else begin
            res = DIM_W'(dim - CFG_W'(1));
        end
        return res;
    endfunction

endpackage

/* hdl/mmu_store.sv */
// ----------------------------------------------------------------------------
// mmu_store
// element memories of the left and right matrix, one write and one
// registered read port each
// ----------------------------------------------------------------------------
module mmu_store
    import mmu_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_wr_a,
    input  logic                     i_wr_b,
    input  logic [ADDR_W-1:0]        i_wr_addr,
    input  logic signed [ELEM_W-1:0] i_wr_data,
    input  logic                     i_rd_en,
    input  logic [ADDR_W-1:0]        i_rd_addr_a,
    input  logic [ADDR_W-1:0]        i_rd_addr_b,
    output logic signed [ELEM_W-1:0] o_rd_a,
    output logic signed [ELEM_W-1:0] o_rd_b
);

    logic signed [ELEM_W-1:0] r_mem_a [DEPTH];
    logic signed [ELEM_W-1:0] r_mem_b [DEPTH];
    logic signed [ELEM_W-1:0] r_rd_a;
    logic signed [ELEM_W-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_wr_a) begin
            r_mem_a[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_a <= r_mem_a[i_rd_addr_a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_b) begin
            r_mem_b[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_b <= r_mem_b[i_rd_addr_b];
        end
    end

    assign o_rd_a = r_rd_a;
    assign o_rd_b = r_rd_b;

endmodule

/* hdl/mmu_seq.sv */
// ----------------------------------------------------------------------------
// mmu_seq
// sequencer: walks i, j and k of one product and issues element reads
// ----------------------------------------------------------------------------
module mmu_seq
    import mmu_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [DIM_W-1:0]   i_m_last,
    input  logic [DIM_W-1:0]   i_k_last,
    input  logic [DIM_W-1:0]   i_n_last,
    input  logic               i_done,
    output logic               o_idle,
    output logic               o_rd_en,
    output logic [ADDR_W-1:0]  o_rd_addr_a,
    output logic [ADDR_W-1:0]  o_rd_addr_b,
    output t_mac_ctl           o_ctl
);

    t_state           r_state, n_state;
    logic [DIM_W-1:0] r_i, n_i;
    logic [DIM_W-1:0] r_j, n_j;
    logic [DIM_W-1:0] r_k, n_k;
    logic [DIM_W-1:0] r_ml, n_ml;
    logic [DIM_W-1:0] r_kl, n_kl;
    logic [DIM_W-1:0] r_nl, n_nl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i  <= n_i;
        r_j  <= n_j;
        r_k  <= n_k;
        r_ml <= n_ml;
        r_kl <= n_kl;
        r_nl <= n_nl;
    end

    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        n_ml    = r_ml;
        n_kl    = r_kl;
        n_nl    = r_nl;
        o_idle  = 1'b0;
        o_rd_en = 1'b0;
        o_ctl   = '0;
        case (r_state)
            ST_IDLE: begin
                o_idle = 1'b1;
                if (i_start) begin
                    n_i     = '0;
                    n_j     = '0;
                    n_k     = '0;
                    n_ml    = i_m_last;
                    n_kl    = i_k_last;
                    n_nl    = i_n_last;
                    n_state = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                o_rd_en        = 1'b1;
                o_ctl.valid    = 1'b1;
                o_ctl.first    = (r_k == '0);
                o_ctl.last     = (r_k == r_kl);
                o_ctl.last_run = (r_k == r_kl) && (r_i == r_ml) && (r_j == r_nl);
                o_ctl.row      = r_i;
                o_ctl.col      = r_j;
                if (r_k == r_kl) begin
                    n_state = ST_WAIT;
                end else begin
                    n_k = r_k + DIM_W'(1);
                end
            end
            ST_WAIT: begin
                if (i_done) begin
                    if ((r_i == r_ml) && (r_j == r_nl)) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_k = '0;
                        if (r_j == r_nl) begin
                            n_j = '0;
                            n_i = r_i + DIM_W'(1);
                        end else begin
                            n_j = r_j + DIM_W'(1);
                        end
                        n_state = ST_ISSUE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_rd_addr_a = {r_i, r_k};
    assign o_rd_addr_b = {r_k, r_j};

endmodule

/* hdl/mmu_mac.sv */
// ----------------------------------------------------------------------------
// mmu_mac
// shared multiply-accumulate unit with the result output register
// ----------------------------------------------------------------------------
module mmu_mac
    import mmu_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_mac_ctl                 i_ctl,
    input  logic signed [ELEM_W-1:0] i_a,
    input  logic signed [ELEM_W-1:0] i_b,
    input  logic                     i_out_ready,
    output logic                     o_done,
    output logic                     o_out_valid,
    output logic [ACC_W-1:0]         o_out_value,
    output logic [DIM_W-1:0]         o_out_row,
    output logic [DIM_W-1:0]         o_out_col,
    output logic                     o_out_last
);

    t_mac_ctl                 r_s1;
    t_mac_ctl                 r_s2;
    logic signed [PROD_W-1:0] r_prod;
    logic [ACC_W-1:0]         r_acc, n_acc;
    logic                     r_hold;
    logic [DIM_W-1:0]         r_hold_row;
    logic [DIM_W-1:0]         r_hold_col;
    logic                     r_hold_last;
    logic                     r_out_valid;
    logic [ACC_W-1:0]         r_out_value;
    logic [DIM_W-1:0]         r_out_row;
    logic [DIM_W-1:0]         r_out_col;
    logic                     r_out_last;
    logic [ACC_W-1:0]         prod_ext;
    logic                     out_free;

    assign prod_ext = {{(ACC_W - PROD_W){r_prod[PROD_W-1]}}, r_prod};
    assign n_acc    = r_s2.first ? prod_ext : r_acc + prod_ext;
    assign out_free = !r_out_valid || i_out_ready;
    assign o_done   = r_hold && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1        <= '0;
            r_s2        <= '0;
            r_hold      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1 <= i_ctl;
            r_s2 <= r_s1;
            if (o_done) begin
                r_hold <= 1'b0;
            end else if (r_s2.valid && r_s2.last) begin
                r_hold <= 1'b1;
            end
            if (o_done) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
        if (r_s2.valid) begin
            r_acc <= n_acc;
        end
        if (r_s2.valid && r_s2.last) begin
            r_hold_row  <= r_s2.row;
            r_hold_col  <= r_s2.col;
            r_hold_last <= r_s2.last_run;
        end
        if (o_done) begin
            r_out_value <= r_acc;
            r_out_row   <= r_hold_row;
            r_out_col   <= r_hold_col;
            r_out_last  <= r_hold_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_value = r_out_value;
    assign o_out_row   = r_out_row;
    assign o_out_col   = r_out_col;
    assign o_out_last  = r_out_last;

endmodule

/* hdl/matrix_multiply_unit.sv */
// ----------------------------------------------------------------------------
// matrix_multiply_unit
// fixed-point matrix product C = A * B, Q8.8 elements, Q20.16 results
//
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tuser req_type, tdata row, col, value
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata value, row, col; tlast last
// cfg       in   i_cfg_valid / o_cfg_ready      i_cfg_index, i_cfg_data
//
// a load item is written when accepted; a compute item walks M*N results,
// each reading K element pairs through the read, multiply and accumulate
// stages of the single multiply-accumulate unit, and waits if m_axis stalls
// s_axis_tready is low while a product is being walked
// a result waiting in the output register does not block the next item
// synchronous active-low reset; element memories are not cleared
// ----------------------------------------------------------------------------
module matrix_multiply_unit
    import mmu_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,  // row_index, col_index, element_value, pad
    input  logic [REQ_W-1:0]     s_axis_tuser,  // req_type
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,  // product_value, out_row, out_col, pad
    output logic                 m_axis_tlast,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    logic [CFG_W-1:0]         r_rows_of_a;
    logic [CFG_W-1:0]         r_inner_size;
    logic [CFG_W-1:0]         r_cols_of_b;
    logic                     in_accept;
    logic                     cfg_accept;
    logic [DIM_W-1:0]         in_row;
    logic [DIM_W-1:0]         in_col;
    logic signed [ELEM_W-1:0] in_value;
    logic                     wr_a;
    logic                     wr_b;
    logic                     start;
    logic                     seq_idle;
    logic                     rd_en;
    logic [ADDR_W-1:0]        rd_addr_a;
    logic [ADDR_W-1:0]        rd_addr_b;
    logic signed [ELEM_W-1:0] rd_a;
    logic signed [ELEM_W-1:0] rd_b;
    t_mac_ctl                 mac_ctl;
    logic                     mac_done;
    logic [ACC_W-1:0]         out_value;
    logic [DIM_W-1:0]         out_row;
    logic [DIM_W-1:0]         out_col;

    assign o_cfg_ready = 1'b1;
    assign cfg_accept  = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_of_a  <= CFG_W'(MAX_DIM);
            r_inner_size <= CFG_W'(MAX_DIM);
            r_cols_of_b  <= CFG_W'(MAX_DIM);
        end else if (cfg_accept) begin
            case (i_cfg_index)
                CFG_ROWS_OF_A:  r_rows_of_a  <= i_cfg_data;
                CFG_INNER_SIZE: r_inner_size <= i_cfg_data;
                CFG_COLS_OF_B:  r_cols_of_b  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign s_axis_tready = seq_idle;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign in_row        = s_axis_tdata[DIM_W-1:0];
    assign in_col        = s_axis_tdata[2*DIM_W-1:DIM_W];
    assign in_value      = s_axis_tdata[2*DIM_W+ELEM_W-1:2*DIM_W];

    always_comb begin
        wr_a  = 1'b0;
        wr_b  = 1'b0;
        start = 1'b0;
        case (t_req'(s_axis_tuser))
            REQ_WR_A:    wr_a  = in_accept;
            REQ_WR_B:    wr_b  = in_accept;
            REQ_COMPUTE: start = in_accept;
            default: ;
        endcase
    end

    mmu_store u_store (
        .i_clk       (i_clk),
        .i_wr_a      (wr_a),
        .i_wr_b      (wr_b),
        .i_wr_addr   ({in_row, in_col}),
        .i_wr_data   (in_value),
        .i_rd_en     (rd_en),
        .i_rd_addr_a (rd_addr_a),
        .i_rd_addr_b (rd_addr_b),
        .o_rd_a      (rd_a),
        .o_rd_b      (rd_b)
    );

    mmu_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_m_last    (last_index(r_rows_of_a)),
        .i_k_last    (last_index(r_inner_size)),
        .i_n_last    (last_index(r_cols_of_b)),
        .i_done      (mac_done),
        .o_idle      (seq_idle),
        .o_rd_en     (rd_en),
        .o_rd_addr_a (rd_addr_a),
        .o_rd_addr_b (rd_addr_b),
        .o_ctl       (mac_ctl)
    );

    mmu_mac u_mac (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (mac_ctl),
        .i_a         (rd_a),
        .i_b         (rd_b),
        .i_out_ready (m_axis_tready),
        .o_done      (mac_done),
        .o_out_valid (m_axis_tvalid),
        .o_out_value (out_value),
        .o_out_row   (out_row),
        .o_out_col   (out_col),
        .o_out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {{(M_TDATA_W - ACC_W - 2 * DIM_W){1'b0}}, out_col, out_row, out_value};

endmodule

/* hdl/mmu_checker.sv */
// ----------------------------------------------------------------------------
// mmu_checker
// port-level checks of the matrix multiply unit, bound to the top level
// ----------------------------------------------------------------------------
`include "matrix_multiply_unit_defines.svh"

module mmu_checker
    import mmu_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    input  logic                 i_s_tready,
    input  logic [REQ_W-1:0]     i_s_tuser,
    input  logic                 i_m_tvalid,
    input  logic                 i_m_tready,
    input  logic [M_TDATA_W-1:0] i_m_tdata,
    input  logic                 i_m_tlast
);

    logic in_acc;
    logic is_load;

    assign in_acc  = i_s_tvalid && i_s_tready;
    assign is_load = (i_s_tuser == REQ_WR_A) || (i_s_tuser == REQ_WR_B);

    // a stalled result holds
    `MMU_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_m_tvalid && !i_m_tready, i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tlast))

    // reset empties the output and opens the input
    `MMU_ASSERT_NXT_ALWAYS(a_reset, i_clk, !i_rst_n, !i_m_tvalid && i_s_tready)

    // a compute item closes the input
    `MMU_ASSERT_NXT(a_busy, i_clk, i_rst_n, in_acc && (i_s_tuser == REQ_COMPUTE), !i_s_tready)

    // a load item leaves the input open
    `MMU_ASSERT_NXT(a_load, i_clk, i_rst_n, in_acc && is_load, i_s_tready)

endmodule

bind matrix_multiply_unit mmu_checker u_mmu_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (s_axis_tvalid),
    .i_s_tready (s_axis_tready),
    .i_s_tuser  (s_axis_tuser),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata),
    .i_m_tlast  (m_axis_tlast)
);
